// ----- rtl/bsps_pkg.sv -----
// Shared types and constants for the beam scan particle scorer.
package bsps_pkg;

  typedef enum logic [1:0] {
    CMD_MAP   = 2'd0,
    CMD_SCAN  = 2'd1,
    CMD_SCORE = 2'd2
  } cmd_e;

  // Sine polynomial coefficients, Q30
  localparam logic [30:0] TRIG_A = 31'd1686629713;
  localparam logic [29:0] TRIG_B = 30'd688904866;
  localparam logic [26:0] TRIG_C = 27'd76016977;

  localparam logic [47:0] LOGW_LIMIT = 48'h8000_0000_0000;

  typedef struct packed {
    logic [1:0]         command;
    logic [15:0]        cell_index;
    logic               cell_occupied;
    logic [5:0]         beam_slot;
    logic [23:0]        measured_range;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [15:0]        heading;
  } in_word_t;

  typedef struct packed {
    logic [8:0]  map_width;
    logic [8:0]  map_height;
    logic [23:0] cells_per_meter;
    logic [15:0] step_length;
    logic [11:0] max_steps;
    logic [23:0] max_range;
    logic [23:0] weight_scale;
  } cfg_t;

endpackage

// ----- rtl/bsps_front.sv -----
// Input side: takes command words, drops unused commands, queues the rest.
module bsps_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  output logic                full_o,
  input  logic                clear_busy_i,
  input  bsps_pkg::in_word_t  word_i,
  output bsps_pkg::in_word_t  word_o,
  output logic                word_valid_o,
  input  logic                word_pop_i
);

  bsps_pkg::in_word_t mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       accept, keep;

  assign full_o = (cnt_q == 2'd2) || clear_busy_i;
  assign accept = push_i && !full_o;
  // unused command code: taken, then forgotten
  assign keep   = (word_i.command == bsps_pkg::CMD_MAP) ||
                  (word_i.command == bsps_pkg::CMD_SCAN) ||
                  (word_i.command == bsps_pkg::CMD_SCORE);

  assign word_valid_o = (cnt_q != 2'd0);
  assign word_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (accept && keep) begin
      mem_q[wr_ptr_q] <= word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (accept && keep) wr_ptr_q <= ~wr_ptr_q;
      if (word_pop_i && word_valid_o) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, accept && keep} - {1'b0, word_pop_i && word_valid_o};
    end
  end

endmodule

// ----- rtl/bsps_back.sv -----
// Execution side: map and scan stores, beam trig, ray march and weight.
module bsps_back #(
  parameter int NUM_BEAMS = 64,
  parameter int MAP_SIDE  = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bsps_pkg::cfg_t     cfg_i,
  input  bsps_pkg::in_word_t word_i,
  input  logic               word_valid_i,
  output logic               word_pop_o,
  output logic               clear_busy_o,
  output logic               res_push_o,
  output logic [47:0]        res_word_o,
  input  logic               res_full_i
);

  localparam int BW  = $clog2(NUM_BEAMS);
  localparam int LIM = (MAP_SIDE < 256) ? MAP_SIDE : 256;
  localparam logic [15:0] OFF_Q = 16'(65536 / NUM_BEAMS);
  localparam logic [BW:0] OFF_R = (BW+1)'(65536 % NUM_BEAMS);

  localparam logic [4:0] S_CLR  = 5'd0;
  localparam logic [4:0] S_IDLE = 5'd1;
  localparam logic [4:0] S_BEAM = 5'd2;
  localparam logic [4:0] S_FOLD = 5'd3;
  localparam logic [4:0] S_TA   = 5'd4;
  localparam logic [4:0] S_TB   = 5'd5;
  localparam logic [4:0] S_TC   = 5'd6;
  localparam logic [4:0] S_TD   = 5'd7;
  localparam logic [4:0] S_TE   = 5'd8;
  localparam logic [4:0] S_STEP = 5'd9;
  localparam logic [4:0] S_MUL  = 5'd10;
  localparam logic [4:0] S_ADR  = 5'd11;
  localparam logic [4:0] S_EVAL = 5'd12;
  localparam logic [4:0] S_ERR  = 5'd13;
  localparam logic [4:0] S_ACC  = 5'd14;
  localparam logic [4:0] S_SC1  = 5'd15;
  localparam logic [4:0] S_SC2  = 5'd16;
  localparam logic [4:0] S_FIN  = 5'd17;

  logic [4:0]  state_q;
  logic [15:0] clr_q;

  // pose and beam bookkeeping
  logic signed [31:0] px_q, py_q;
  logic [15:0]        heading_q, off_q, ang_q;
  logic [BW:0]        rem_q;
  logic [BW-1:0]      b_q;
  logic [47:0]        sum_q;

  // trig unit
  logic        sel_q, neg_q;
  logic [14:0] t_q;
  logic [30:0] z2_q, mid_q, s_q;
  logic [29:0] inner_q;
  logic signed [17:0] dx_q, dy_q;

  // march
  logic signed [33:0] x_q, y_q;
  logic signed [58:0] cx_q, cy_q;
  logic [27:0] r_q, range_q;
  logic [11:0] i_q;
  logic        oob_q;

  // weight
  logic [55:0] sq_q;
  logic [47:0] hi_q;
  logic [23:0] lo_q;
  logic        sat_q;

  // stores
  logic        map_mem [65536];
  logic        occ_q;
  logic [23:0] scan_mem [64];
  logic [63:0] scan_vld_q;
  logic [23:0] scan_rd_q;
  logic        scan_ok_q;

  logic [8:0]  w_lim, h_lim;
  logic [15:0] trig_a, tx;
  logic [14:0] t_fold;
  logic [30:0] z;
  logic [61:0] p_ta, p_td;
  logic [57:0] p_tb;
  logic [60:0] p_tc;
  logic [46:0] p_te;
  logic [16:0] m_te;
  logic signed [17:0] step_v;
  logic [26:0] ix, iy;
  logic [16:0] addr_w;
  logic        oob;
  logic [5:0]  sidx;
  logic signed [28:0] dz;
  logic [27:0] mag;
  logic [48:0] scaled;
  logic [47:0] final_v;
  logic        map_we;
  logic [15:0] map_wa;
  logic        map_wd;
  logic        is_score, is_scan, is_map;

  assign w_lim = (cfg_i.map_width  > 9'(LIM)) ? 9'(LIM) : cfg_i.map_width;
  assign h_lim = (cfg_i.map_height > 9'(LIM)) ? 9'(LIM) : cfg_i.map_height;

  assign is_map   = (word_i.command == bsps_pkg::CMD_MAP);
  assign is_scan  = (word_i.command == bsps_pkg::CMD_SCAN);
  assign is_score = (word_i.command == bsps_pkg::CMD_SCORE);

  assign clear_busy_o = (state_q == S_CLR);
  assign word_pop_o   = (state_q == S_IDLE) && word_valid_i;

  // quarter-wave fold; cosine is sine a quarter turn ahead
  always_comb begin
    trig_a = sel_q ? ang_q : ang_q + 16'h4000;
    tx     = {2'b00, trig_a[13:0]};
    t_fold = trig_a[14] ? 15'(16'h4000 - tx) : tx[14:0];
  end

  assign z    = {t_q, 16'h0000};
  assign p_ta = 62'(z) * 62'(z);
  assign p_tb = 58'(z2_q) * 58'(bsps_pkg::TRIG_C);
  assign p_tc = 61'(z2_q) * 61'(inner_q);
  assign p_td = 62'(z) * 62'(mid_q);
  assign p_te = 47'(s_q) * 47'(cfg_i.step_length);
  assign m_te = p_te[46:30];
  assign step_v = neg_q ? -$signed({1'b0, m_te}) : $signed({1'b0, m_te});

  // cell lookup from registered products
  assign ix     = cx_q[58:32];
  assign iy     = cy_q[58:32];
  assign oob    = cx_q[58] || cy_q[58] || (ix >= 27'(w_lim)) || (iy >= 27'(h_lim));
  assign addr_w = (17'(iy[7:0]) * 17'(w_lim)) + 17'(ix[7:0]);

  assign sidx = 6'(b_q);
  assign dz   = $signed({5'b0, (scan_ok_q ? scan_rd_q : 24'd0)}) - $signed({1'b0, range_q});
  assign mag  = dz[28] ? 28'(-dz) : dz[27:0];

  assign scaled  = 49'(hi_q) + 49'(lo_q);
  assign final_v = (sat_q || scaled > 49'(bsps_pkg::LOGW_LIMIT)) ? bsps_pkg::LOGW_LIMIT
                                                                : scaled[47:0];
  assign res_word_o = 48'd0 - final_v;
  assign res_push_o = (state_q == S_FIN) && !res_full_i;

  // map store: clearing pass, cell writes, one registered read
  assign map_we = (state_q == S_CLR) || (word_pop_o && is_map);
  assign map_wa = (state_q == S_CLR) ? clr_q : word_i.cell_index;
  assign map_wd = (state_q == S_CLR) ? 1'b0 : word_i.cell_occupied;

  always_ff @(posedge clk_i) begin
    if (map_we) map_mem[map_wa] <= map_wd;
    if (state_q == S_ADR) occ_q <= map_mem[addr_w[15:0]];
  end

  always_ff @(posedge clk_i) begin
    if (word_pop_o && is_scan) scan_mem[word_i.beam_slot] <= word_i.measured_range;
    if (state_q == S_BEAM) begin
      scan_rd_q <= scan_mem[sidx];
      scan_ok_q <= scan_vld_q[sidx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLR;
      clr_q      <= '0;
      scan_vld_q <= '0;
      b_q        <= '0;
      sel_q      <= 1'b0;
      i_q        <= '0;
    end else begin
      case (state_q)
        S_CLR: begin
          clr_q <= clr_q + 16'd1;
          if (clr_q == 16'hFFFF) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (word_valid_i) begin
            if (is_scan) scan_vld_q[word_i.beam_slot] <= 1'b1;
            if (is_score) begin
              px_q      <= word_i.pos_x;
              py_q      <= word_i.pos_y;
              heading_q <= word_i.heading;
              b_q       <= '0;
              off_q     <= '0;
              rem_q     <= '0;
              sum_q     <= '0;
              state_q   <= S_BEAM;
            end
          end
        end
        S_BEAM: begin
          ang_q   <= heading_q + off_q + 16'h8000;
          sel_q   <= 1'b0;
          state_q <= S_FOLD;
        end
        S_FOLD: begin
          t_q     <= t_fold;
          neg_q   <= trig_a[15];
          state_q <= S_TA;
        end
        S_TA: begin
          z2_q    <= 31'(p_ta >> 30);
          state_q <= S_TB;
        end
        S_TB: begin
          inner_q <= bsps_pkg::TRIG_B - 30'(p_tb >> 30);
          state_q <= S_TC;
        end
        S_TC: begin
          mid_q   <= bsps_pkg::TRIG_A - 31'(p_tc >> 30);
          state_q <= S_TD;
        end
        S_TD: begin
          s_q     <= 31'(p_td >> 30);
          state_q <= S_TE;
        end
        S_TE: begin
          if (!sel_q) begin
            dx_q    <= step_v;
            sel_q   <= 1'b1;
            state_q <= S_FOLD;
          end else begin
            dy_q <= step_v;
            x_q  <= 34'(px_q);
            y_q  <= 34'(py_q);
            r_q  <= '0;
            i_q  <= '0;
            if (cfg_i.max_steps == 12'd0) begin
              range_q <= 28'(cfg_i.max_range);
              state_q <= S_ERR;
            end else begin
              state_q <= S_STEP;
            end
          end
        end
        S_STEP: begin
          x_q     <= x_q + 34'(dx_q);
          y_q     <= y_q + 34'(dy_q);
          r_q     <= r_q + 28'(cfg_i.step_length);
          i_q     <= i_q + 12'd1;
          state_q <= S_MUL;
        end
        S_MUL: begin
          cx_q    <= 59'(x_q) * 59'($signed({1'b0, cfg_i.cells_per_meter}));
          cy_q    <= 59'(y_q) * 59'($signed({1'b0, cfg_i.cells_per_meter}));
          state_q <= S_ADR;
        end
        S_ADR: begin
          oob_q   <= oob;
          state_q <= S_EVAL;
        end
        S_EVAL: begin
          if (oob_q || occ_q) begin
            range_q <= r_q;
            state_q <= S_ERR;
          end else if (i_q == cfg_i.max_steps) begin
            range_q <= 28'(cfg_i.max_range);
            state_q <= S_ERR;
          end else begin
            state_q <= S_STEP;
          end
        end
        S_ERR: begin
          sq_q    <= 56'(mag) * 56'(mag);
          state_q <= S_ACC;
        end
        S_ACC: begin
          sum_q <= sum_q + 48'(sq_q >> 16);
          if (rem_q + OFF_R >= (BW+1)'(NUM_BEAMS)) begin
            rem_q <= rem_q + OFF_R - (BW+1)'(NUM_BEAMS);
            off_q <= off_q + OFF_Q + 16'd1;
          end else begin
            rem_q <= rem_q + OFF_R;
            off_q <= off_q + OFF_Q;
          end
          b_q <= b_q + 1'b1;
          if (b_q == BW'(NUM_BEAMS - 1)) state_q <= S_SC1;
          else                           state_q <= S_BEAM;
        end
        S_SC1: begin
          hi_q    <= 48'(sum_q[39:16]) * 48'(cfg_i.weight_scale);
          sat_q   <= (sum_q[47:16] > 32'h0080_0000);
          state_q <= S_SC2;
        end
        S_SC2: begin
          lo_q    <= 24'((40'(sum_q[15:0]) * 40'(cfg_i.weight_scale)) >> 16);
          state_q <= S_FIN;
        end
        S_FIN: begin
          if (!res_full_i) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_clear_no_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLR) |-> !word_pop_o)
    else $error("command word taken during map clear");

  a_weight_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> (res_word_o[47] || (res_word_o == 48'd0)))
    else $error("log weight is positive");

  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EVAL) |-> ((i_q != 12'd0) && (i_q <= cfg_i.max_steps)))
    else $error("march step count out of bounds");

  a_push_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> $past(state_q) == S_SC2 || $past(state_q) == S_FIN)
    else $error("result pushed outside the finish step");

endmodule

// ----- rtl/beam_scan_particle_scorer.sv -----
// Top level of the beam scan particle scorer: config registers, result queue.
//
// Scores a particle pose against a stored range scan over a stored occupancy
// grid. Words go in through a push/full queue: command 0 writes a map cell,
// command 1 writes a scan beam range, command 2 scores a pose and later gives
// one log weight word on the empty/pop side; command 3 is taken and dropped.
// After reset the map is swept clear, one cell per clock, and full stays high
// until the sweep ends; config writes are taken meanwhile. A score runs one beam
// at a time through a shared trig unit and a single map read port; steps marched
// per beam are at most max_steps, and each march step goes through position
// update, two cell multiplies, address and map read, and hit check. A two-word
// front queue and a two-word result queue let the sender and receiver stall
// independently of the scoring engine.
module beam_scan_particle_scorer #(
  parameter int NUM_BEAMS = 64,
  parameter int MAP_SIDE  = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         command_i,
  input  logic [15:0]        cell_index_i,
  input  logic               cell_occupied_i,
  input  logic [5:0]         beam_slot_i,
  input  logic [23:0]        measured_range_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic [15:0]        heading_i,
  output logic               empty,
  input  logic               pop,
  output logic signed [47:0] log_weight_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [23:0]        cfg_data_i
);

  localparam logic [2:0] CFG_MAP_W  = 3'd0;
  localparam logic [2:0] CFG_MAP_H  = 3'd1;
  localparam logic [2:0] CFG_CPM    = 3'd2;
  localparam logic [2:0] CFG_STEP   = 3'd3;
  localparam logic [2:0] CFG_MSTEPS = 3'd4;
  localparam logic [2:0] CFG_MRANGE = 3'd5;
  localparam logic [2:0] CFG_WSCALE = 3'd6;

  bsps_pkg::cfg_t     cfg_q;
  bsps_pkg::in_word_t in_word, q_word;
  logic        q_valid, q_pop, clear_busy;
  logic        res_push, res_full;
  logic [47:0] res_word;

  // result queue, two words
  logic [47:0] out_mem_q [2];
  logic        out_wr_q, out_rd_q;
  logic [1:0]  out_cnt_q;
  logic        out_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.map_width       <= 9'd256;
      cfg_q.map_height      <= 9'd256;
      cfg_q.cells_per_meter <= 24'd1310720;
      cfg_q.step_length     <= 16'd8192;
      cfg_q.max_steps       <= 12'd256;
      cfg_q.max_range       <= 24'd2097152;
      cfg_q.weight_scale    <= 24'd3276800;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_MAP_W:  cfg_q.map_width       <= cfg_data_i[8:0];
        CFG_MAP_H:  cfg_q.map_height      <= cfg_data_i[8:0];
        CFG_CPM:    cfg_q.cells_per_meter <= cfg_data_i;
        CFG_STEP:   cfg_q.step_length     <= cfg_data_i[15:0];
        CFG_MSTEPS: cfg_q.max_steps       <= cfg_data_i[11:0];
        CFG_MRANGE: cfg_q.max_range       <= cfg_data_i;
        CFG_WSCALE: cfg_q.weight_scale    <= cfg_data_i;
        default: ;  // no register there
      endcase
    end
  end

  assign in_word.command        = command_i;
  assign in_word.cell_index     = cell_index_i;
  assign in_word.cell_occupied  = cell_occupied_i;
  assign in_word.beam_slot      = beam_slot_i;
  assign in_word.measured_range = measured_range_i;
  assign in_word.pos_x          = pos_x_i;
  assign in_word.pos_y          = pos_y_i;
  assign in_word.heading        = heading_i;

  bsps_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .clear_busy_i (clear_busy),
    .word_i       (in_word),
    .word_o       (q_word),
    .word_valid_o (q_valid),
    .word_pop_i   (q_pop)
  );

  bsps_back #(
    .NUM_BEAMS (NUM_BEAMS),
    .MAP_SIDE  (MAP_SIDE)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .word_i       (q_word),
    .word_valid_i (q_valid),
    .word_pop_o   (q_pop),
    .clear_busy_o (clear_busy),
    .res_push_o   (res_push),
    .res_word_o   (res_word),
    .res_full_i   (res_full)
  );

  assign res_full     = (out_cnt_q == 2'd2);
  assign empty        = (out_cnt_q == 2'd0);
  assign out_take     = pop && !empty;
  assign log_weight_o = $signed(out_mem_q[out_rd_q]);

  always_ff @(posedge clk_i) begin
    if (res_push) out_mem_q[out_wr_q] <= res_word;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_wr_q  <= 1'b0;
      out_rd_q  <= 1'b0;
      out_cnt_q <= 2'd0;
    end else begin
      if (res_push) out_wr_q <= ~out_wr_q;
      if (out_take) out_rd_q <= ~out_rd_q;
      out_cnt_q <= out_cnt_q + {1'b0, res_push} - {1'b0, out_take};
    end
  end

endmodule
